// ----- rtl/rsfr_pkg.sv -----
// shared types and constants for the rs485 slave frame responder
// no dependencies
`default_nettype none

package rsfr_pkg;

  localparam logic [7:0] START_MARK = 8'h23;
  localparam logic [7:0] HEAD_MARK  = 8'h2A;
  localparam logic [7:0] END_MARK   = 8'h24;

  localparam logic [2:0] CMD_STATUS  = 3'd1;
  localparam logic [2:0] CMD_VERSION = 3'd2;
  localparam logic [2:0] CMD_MEASURE = 3'd3;
  localparam logic [2:0] CMD_DATA    = 3'd4;

  localparam logic [2:0] REG_OWN_ADDRESS = 3'd0;
  localparam logic [2:0] REG_FW_VERSION  = 3'd1;
  localparam logic [2:0] REG_MEAS_VALUE  = 3'd2;
  localparam logic [2:0] REG_NODE_STATUS = 3'd3;
  localparam logic [2:0] REG_SENSOR_KIND = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  // reply request handed from the parser to the reply builder
  typedef struct packed {
    logic [2:0] cmd;
  } req_t;

endpackage

`default_nettype wire

// ----- rtl/rs485_slave_frame_responder_core.sv -----
// Takes received bytes on the s_ stream, one per cycle, and answers request
// frames '#', dest, src, '*', cmd, payload, '$', sum that are addressed to this
// node, carry a good checksum and a command from 1 to 4. A reply of 8 to 12
// bytes leaves on the m_ stream, one word per cycle while m_tready is high,
// tlast on its checksum byte. Up to two replies wait in a queue; s_tready
// drops only while that queue is full, so input runs at one word per cycle as
// long as replies are drained. Configuration writes are taken at any cycle with
// cfg_we high and should happen while no frame is in progress.
// depends on rsfr_pkg, rsfr_front, rsfr_queue, rsfr_back
`default_nettype none

module rs485_slave_frame_responder_core import rsfr_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] tx_byte
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [7:0]  own_address;
  logic [15:0] firmware_version;
  logic [31:0] measurement_value;
  logic [7:0]  node_status;
  logic [7:0]  sensor_kind;

  logic take;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;
  req_t push_req;
  req_t head_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= 8'd1;
      firmware_version  <= 16'h0110;
      measurement_value <= 32'd10;
      node_status       <= 8'd0;
      sensor_kind       <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_ADDRESS: own_address       <= cfg_data[7:0];
        REG_FW_VERSION:  firmware_version  <= cfg_data[15:0];
        REG_MEAS_VALUE:  measurement_value <= cfg_data;
        REG_NODE_STATUS: node_status       <= cfg_data[7:0];
        REG_SENSOR_KIND: sensor_kind       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  rsfr_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (s_tdata),
    .own_address (own_address),
    .push        (push),
    .req         (push_req)
  );

  rsfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_req  (push_req),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_req)
  );

  rsfr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (q_not_empty),
    .req               (head_req),
    .pop               (pop),
    .own_address       (own_address),
    .firmware_version  (firmware_version),
    .measurement_value (measurement_value),
    .node_status       (node_status),
    .sensor_kind       (sensor_kind),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tlast           (m_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/rsfr_front.sv -----
// frame parser: hunts for request frames and checks sum, address and command
// depends on rsfr_pkg
`default_nettype none

module rsfr_front import rsfr_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] own_address,
  output logic            push,
  output req_t            req
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = LEN_W + 2;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAME_BYTES);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_DEST = 3'd1;
  localparam logic [2:0] PH_SRC  = 3'd2;
  localparam logic [2:0] PH_STAR = 3'd3;
  localparam logic [2:0] PH_CMD  = 3'd4;
  localparam logic [2:0] PH_BODY = 3'd5;
  localparam logic [2:0] PH_CSUM = 3'd6;

  logic [2:0]       phase, phase_next;
  logic [7:0]       sum, sum_next;
  logic [7:0]       dest, dest_next;
  logic [7:0]       cmd, cmd_next;
  logic [LEN_W-1:0] len, len_next;
  logic [CMP_W-1:0] len_ext;
  logic             cmd_known;

  assign len_ext   = CMP_W'(len);
  assign cmd_known = (cmd == 8'(CMD_STATUS)) || (cmd == 8'(CMD_VERSION)) ||
                     (cmd == 8'(CMD_MEASURE)) || (cmd == 8'(CMD_DATA));

  always_comb begin
    phase_next = phase;
    sum_next   = sum;
    dest_next  = dest;
    cmd_next   = cmd;
    len_next   = len;
    push       = 1'b0;
    req.cmd    = cmd[2:0];
    if (take) begin
      unique case (phase)
        PH_DEST: begin
          dest_next  = rx_byte;
          sum_next   = sum + rx_byte;
          len_next   = LEN_W'(2);
          phase_next = PH_SRC;
        end
        PH_SRC: begin
          sum_next   = sum + rx_byte;
          len_next   = LEN_W'(3);
          phase_next = PH_STAR;
        end
        PH_STAR: begin
          if (rx_byte == HEAD_MARK) begin
            sum_next   = sum + rx_byte;
            len_next   = LEN_W'(4);
            phase_next = PH_CMD;
          end else begin
            phase_next = PH_HUNT;
            sum_next   = '0;
            len_next   = '0;
          end
        end
        PH_CMD: begin
          cmd_next   = rx_byte;
          sum_next   = sum + rx_byte;
          len_next   = LEN_W'(5);
          phase_next = PH_BODY;
        end
        PH_BODY: begin
          if (rx_byte == END_MARK) begin
            if (len_ext + CMP_W'(2) > MAX_LEN) begin
              phase_next = PH_HUNT;
              sum_next   = '0;
              len_next   = '0;
            end else begin
              len_next   = len + LEN_W'(1);
              phase_next = PH_CSUM;
            end
          end else if (len_ext + CMP_W'(3) > MAX_LEN) begin
            phase_next = PH_HUNT;
            sum_next   = '0;
            len_next   = '0;
          end else begin
            sum_next = sum + rx_byte;
            len_next = len + LEN_W'(1);
          end
        end
        PH_CSUM: begin
          push       = (rx_byte == sum) && (dest == own_address) && cmd_known;
          phase_next = PH_HUNT;
          sum_next   = '0;
          len_next   = '0;
        end
        default: begin
          // hunting, and any phase code without meaning
          if (rx_byte == START_MARK) begin
            sum_next   = rx_byte;
            len_next   = LEN_W'(1);
            phase_next = PH_DEST;
          end else begin
            phase_next = PH_HUNT;
            sum_next   = '0;
            len_next   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      sum   <= '0;
      dest  <= '0;
      cmd   <= '0;
      len   <= '0;
    end else begin
      phase <= phase_next;
      sum   <= sum_next;
      dest  <= dest_next;
      cmd   <= cmd_next;
      len   <= len_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rsfr_queue.sv -----
// short queue of reply requests between parser and reply builder
// depends on rsfr_pkg
`default_nettype none

module rsfr_queue import rsfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_req,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output req_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rsfr_back.sv -----
// reply builder: walks one reply a byte per cycle into an output register while m_tready allows
// depends on rsfr_pkg
`default_nettype none

module rsfr_back import rsfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire req_t        req,
  output logic             pop,
  input  wire logic [7:0]  own_address,
  input  wire logic [15:0] firmware_version,
  input  wire logic [31:0] measurement_value,
  input  wire logic [7:0]  node_status,
  input  wire logic [7:0]  sensor_kind,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  logic [3:0] idx;
  logic [3:0] last_idx;
  logic [7:0] sum;
  logic [7:0] body_byte;
  logic [7:0] cur_byte;
  logic [7:0] sum_base;
  logic       load;
  logic       is_last;

  always_comb begin
    unique case (req.cmd)
      CMD_STATUS:  last_idx = 4'd10;
      CMD_MEASURE: last_idx = 4'd7;
      default:     last_idx = 4'd11;
    endcase
  end

  // command-specific body, body byte k sits at reply byte 6 + k
  always_comb begin
    body_byte = 8'h00;
    case (req.cmd)
      CMD_STATUS: begin
        case (idx)
          4'd6:    body_byte = node_status;
          4'd8:    body_byte = sensor_kind;
          default: body_byte = 8'h00;
        endcase
      end
      CMD_VERSION: begin
        case (idx)
          4'd6:    body_byte = firmware_version[7:0];
          4'd7:    body_byte = firmware_version[15:8];
          default: body_byte = 8'h00;
        endcase
      end
      CMD_DATA: begin
        case (idx)
          4'd6:    body_byte = measurement_value[7:0];
          4'd7:    body_byte = measurement_value[15:8];
          4'd8:    body_byte = measurement_value[23:16];
          4'd9:    body_byte = measurement_value[31:24];
          default: body_byte = 8'h00;
        endcase
      end
      default: body_byte = 8'h00;
    endcase
  end

  always_comb begin
    is_last = (idx == last_idx);
    if (is_last) begin
      cur_byte = sum;
    end else if (idx == last_idx - 4'd1) begin
      cur_byte = END_MARK;
    end else begin
      case (idx)
        4'd0:    cur_byte = START_MARK;
        4'd1:    cur_byte = 8'h00;
        4'd2:    cur_byte = own_address;
        4'd3:    cur_byte = HEAD_MARK;
        4'd4:    cur_byte = {5'd0, req.cmd};
        4'd5:    cur_byte = 8'h00;
        default: cur_byte = body_byte;
      endcase
    end
  end

  assign load     = req_valid && (!m_tvalid || m_tready);
  assign pop      = load && is_last;
  assign sum_base = (idx == 4'd0) ? 8'h00 : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        idx      <= is_last ? 4'd0 : idx + 4'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur_byte;
      m_tlast <= is_last;
      // the end mark stays out of the reply sum
      sum     <= (idx == last_idx - 4'd1) ? sum : sum_base + cur_byte;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_rs485_slave_frame_responder_core.sv -----
// self-checking bench for rs485_slave_frame_responder_core: request frames in, reply words out
// keeps its own frame parser and reply builder to predict every reply word
// depends on rsfr_pkg and the rtl of the core
`timescale 1ns / 100ps

module tb_rs485_slave_frame_responder_core import rsfr_pkg::*;;

  localparam int MAX_FRAME   = 20;
  localparam int MAX_BODY    = MAX_FRAME - 7;  // payload bytes that still fit
  localparam int HOLD_CYCLES = 160;
  localparam int SETTLE      = 8;

  typedef enum logic [2:0] {
    PH_HUNT, PH_DEST, PH_SRC, PH_STAR, PH_CMD, PH_BODY, PH_CSUM
  } parse_ph_t;

  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } reply_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] tx_byte
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_OWN_ADDRESS;
  logic [31:0] cfg_data = 32'h0;

  // predictor state and its copy of the registers
  parse_ph_t   rx_phase = PH_HUNT;
  logic [7:0]  frame_sum = 8'h00;
  logic [7:0]  frame_dst = 8'h00;
  logic [7:0]  frame_cmd = 8'h00;
  int          frame_len = 0;
  logic [7:0]  own_addr = 8'd1;
  logic [15:0] fw_version = 16'd272;
  logic [31:0] meas_value = 32'd10;
  logic [7:0]  status_byte = 8'd0;
  logic [7:0]  sensor_byte = 8'd0;

  logic [7:0]  rx_pending[$];
  reply_word_t reply_expect[$];
  int          rx_queued = 0;
  int          rx_accepted = 0;
  int          mismatch_cnt = 0;

  logic        in_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  bit          src_steady = 1'b0;
  sink_mode_t  sink_mode = SINK_RANDOM;
  logic [7:0]  stall_pat = 8'b1011_0010;
  int          hold_left = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;

  rs485_slave_frame_responder_core #(.MAX_FRAME_BYTES(MAX_FRAME)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic restart_hunt();
    rx_phase  = PH_HUNT;
    frame_sum = 8'h00;
    frame_len = 0;
  endtask

  task automatic queue_reply();
    logic [7:0] msg[$];
    logic [7:0] sum;
    bit         known;
    reply_word_t w;
    known = 1'b1;
    msg.push_back(START_MARK);
    msg.push_back(8'h00);
    msg.push_back(own_addr);
    msg.push_back(HEAD_MARK);
    msg.push_back(frame_cmd);
    msg.push_back(8'h00);
    case (frame_cmd)
      {5'd0, CMD_STATUS}: begin
        msg.push_back(status_byte);
        msg.push_back(8'h00);
        msg.push_back(sensor_byte);
      end
      {5'd0, CMD_VERSION}: begin
        msg.push_back(fw_version[7:0]);
        msg.push_back(fw_version[15:8]);
        msg.push_back(8'h00);
        msg.push_back(8'h00);
      end
      {5'd0, CMD_MEASURE}: ;
      {5'd0, CMD_DATA}: begin
        msg.push_back(meas_value[7:0]);
        msg.push_back(meas_value[15:8]);
        msg.push_back(meas_value[23:16]);
        msg.push_back(meas_value[31:24]);
      end
      default: known = 1'b0;
    endcase
    if (!known) return;
    sum = 8'h00;
    foreach (msg[k]) sum += msg[k];
    msg.push_back(END_MARK);
    msg.push_back(sum);
    foreach (msg[k]) begin
      w.tx_byte = msg[k];
      w.tx_last = (k == msg.size() - 1);
      reply_expect.push_back(w);
    end
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    case (rx_phase)
      PH_DEST: begin
        frame_dst = b;
        frame_sum += b;
        frame_len = 2;
        rx_phase  = PH_SRC;
      end
      PH_SRC: begin
        frame_sum += b;
        frame_len = 3;
        rx_phase  = PH_STAR;
      end
      PH_STAR: begin
        if (b == HEAD_MARK) begin
          frame_sum += b;
          frame_len = 4;
          rx_phase  = PH_CMD;
        end else begin
          restart_hunt();
        end
      end
      PH_CMD: begin
        // taken as the command even when it equals the end mark
        frame_cmd = b;
        frame_sum += b;
        frame_len = 5;
        rx_phase  = PH_BODY;
      end
      PH_BODY: begin
        if (b == END_MARK) begin
          if (frame_len + 2 > MAX_FRAME) begin
            restart_hunt();
          end else begin
            frame_len++;
            rx_phase = PH_CSUM;
          end
        end else if (frame_len + 3 > MAX_FRAME) begin
          restart_hunt();
        end else begin
          frame_sum += b;
          frame_len++;
        end
      end
      PH_CSUM: begin
        if (b == frame_sum && frame_dst == own_addr) queue_reply();
        restart_hunt();
      end
      default: begin
        if (b == START_MARK) begin
          frame_sum = b;
          frame_len = 1;
          rx_phase  = PH_DEST;
        end else begin
          restart_hunt();
        end
      end
    endcase
  endtask

  // sender: bursts of words with random gaps between them, no gaps while src_steady
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (rx_pending.size() != 0) begin
        s_tdata  <= rx_pending.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left   <= src_steady ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: open, random or patterned stalls by sink_mode, plus one long hold-off when armed
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[7:1]};
      case (sink_mode)
        SINK_OPEN:   m_tready <= 1'b1;
        SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
        default:     m_tready <= stall_pat[0];
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    reply_word_t want;
    in_taken <= s_tvalid && s_tready;
    if (s_tvalid && s_tready) begin
      take_rx_byte(s_tdata);
      rx_accepted++;
    end
    if (m_tvalid && m_tready) begin
      if (reply_expect.size() == 0) begin
        $error("reply word with none expected: tx_byte %h tx_last %b", m_tdata, m_tlast);
        mismatch_cnt++;
      end else begin
        want = reply_expect.pop_front();
        if (m_tdata !== want.tx_byte) begin
          $error("tx_byte expected %h actual %h", want.tx_byte, m_tdata);
          mismatch_cnt++;
        end
        if (m_tlast !== want.tx_last) begin
          $error("tx_last expected %b actual %b", want.tx_last, m_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic queue_rx(input logic [7:0] b);
    rx_pending.push_back(b);
    rx_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] dst, input logic [7:0] cmd, input int body_len,
                             input bit sum_ok, input bit star_ok);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] flip;
    queue_rx(START_MARK);
    sum = START_MARK;
    queue_rx(dst);
    sum += dst;
    b = 8'($urandom_range(0, 255));
    queue_rx(b);
    sum += b;
    if (!star_ok) begin
      b = $urandom_range(0, 1) ? START_MARK : 8'($urandom_range(0, 255));
      if (b == HEAD_MARK) b = 8'h00;
      queue_rx(b);
      return;
    end
    queue_rx(HEAD_MARK);
    sum += HEAD_MARK;
    queue_rx(cmd);
    sum += cmd;
    for (int k = 0; k < body_len; k++) begin
      b = 8'($urandom_range(0, 255));
      if (b == END_MARK) b = 8'h00;
      // the word that overflows a frame must not restart one
      if (k == MAX_BODY) b = START_MARK;
      queue_rx(b);
      sum += b;
    end
    queue_rx(END_MARK);
    flip = 8'($urandom_range(1, 255));
    queue_rx(sum_ok ? sum : sum ^ flip);
  endtask

  task automatic queue_random_frame();
    logic [7:0] dst;
    logic [7:0] cmd;
    int         r;
    int         body_len;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      for (int k = $urandom_range(1, 3); k > 0; k--) queue_rx(8'($urandom_range(0, 255)));
    end
    dst = ($urandom_range(0, 99) < 85) ? own_addr : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 80)      cmd = 8'($urandom_range(1, 4));
    else if (r < 86) cmd = 8'h00;
    else if (r < 93) cmd = 8'($urandom_range(5, 255));
    else             cmd = END_MARK;
    r = $urandom_range(0, 99);
    if (r < 90)      body_len = $urandom_range(0, 4);
    else if (r < 95) body_len = MAX_BODY;
    else             body_len = $urandom_range(MAX_BODY + 1, MAX_BODY + 3);
    queue_frame(dst, cmd, body_len, $urandom_range(0, 99) < 90, $urandom_range(0, 99) < 95);
  endtask

  task automatic run_random(input int n_words);
    int stop_at;
    stop_at = rx_queued + n_words;
    while (rx_queued < stop_at) queue_random_frame();
  endtask

  task automatic wait_idle();
    while (rx_accepted != rx_queued || reply_expect.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_OWN_ADDRESS: own_addr    = val[7:0];
      REG_FW_VERSION:  fw_version  = val[15:0];
      REG_MEAS_VALUE:  meas_value  = val;
      REG_NODE_STATUS: status_byte = val[7:0];
      REG_SENSOR_KIND: sensor_byte = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [15:0] fw,
                            input logic [31:0] meas, input logic [7:0] st,
                            input logic [7:0] kind);
    write_reg(REG_OWN_ADDRESS, {24'd0, addr});
    write_reg(REG_FW_VERSION, {16'd0, fw});
    write_reg(REG_MEAS_VALUE, meas);
    write_reg(REG_NODE_STATUS, {24'd0, st});
    write_reg(REG_SENSOR_KIND, {24'd0, kind});
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed part, register values from reset
    queue_rx(8'h00);
    queue_rx(8'hFF);
    queue_rx(END_MARK);
    queue_rx(HEAD_MARK);
    queue_frame(8'd1, {5'd0, CMD_STATUS}, 0, 1'b1, 1'b1);
    queue_frame(8'd1, {5'd0, CMD_VERSION}, 1, 1'b1, 1'b1);
    queue_frame(8'd1, {5'd0, CMD_MEASURE}, MAX_BODY, 1'b1, 1'b1);
    queue_frame(8'd1, {5'd0, CMD_DATA}, 0, 1'b1, 1'b1);
    // start mark where the star belongs is dropped, not taken as a new frame
    queue_rx(START_MARK);
    queue_rx(8'd1);
    queue_rx(8'h55);
    queue_rx(START_MARK);
    queue_frame(8'd1, {5'd0, CMD_MEASURE}, 0, 1'b1, 1'b1);
    queue_frame(8'd1, {5'd0, CMD_STATUS}, MAX_BODY + 1, 1'b1, 1'b1);
    queue_frame(8'd1, END_MARK, 0, 1'b1, 1'b1);
    queue_frame(8'd1, {5'd0, CMD_STATUS}, 0, 1'b0, 1'b1);
    queue_frame(8'd2, {5'd0, CMD_STATUS}, 0, 1'b1, 1'b1);
    queue_frame(8'd1, 8'h00, 0, 1'b1, 1'b1);
    queue_frame(8'd1, 8'hFF, 2, 1'b1, 1'b1);
    queue_frame(8'd1, {5'd0, CMD_DATA}, 0, 1'b1, 1'b1);
    wait_idle();

    set_config(8'h00, 16'h0000, 32'h0000_0000, 8'h00, 8'h00);
    sink_mode = SINK_PATTERN;
    run_random(20);
    wait_idle();

    // long hold-off on the reply side while words keep coming
    set_config(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    src_steady = 1'b1;
    sink_mode  = SINK_RANDOM;
    hold_arm   = 1'b1;
    run_random(30);
    wait_idle();

    set_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), $urandom(),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    sink_mode = SINK_OPEN;
    run_random(16);
    wait_idle();

    set_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), $urandom(),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    src_steady = 1'b0;
    sink_mode  = SINK_RANDOM;
    run_random(16);
    wait_idle();
    repeat (4 * SETTLE) @(negedge clk);

    if (mismatch_cnt == 0 && reply_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
